// ===== rtl/psomppt_pkg.sv =====
// ----------------------------------------------------------------------------
// psomppt_pkg
// Shared constants, register codes and helpers for the particle swarm
// maximum power point tracker.
// ----------------------------------------------------------------------------
package psomppt_pkg;

    localparam int DEF_MAX_PARTICLES = 16;

    localparam logic [15:0] RST_MAX_VOLTAGE     = 16'd11520;
    localparam logic [15:0] RST_COGNITIVE_GAIN  = 16'd6144;
    localparam logic [15:0] RST_SOCIAL_GAIN     = 16'd6144;
    localparam logic [15:0] RST_INERTIA_WEIGHT  = 16'd1638;
    localparam logic [4:0]  RST_PARTICLE_COUNT  = 5'd4;
    localparam logic [7:0]  RST_ITERATION_LIMIT = 8'd10;
    localparam logic [31:0] RST_POWER_THRESHOLD = 32'd44237;

    localparam logic [15:0] RND_033 = 16'd21627;
    localparam logic [15:0] RND_066 = 16'd43254;
    localparam logic [15:0] K2_NUM  = 16'd983;

    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_SWARM = 2'd1;
    localparam logic [1:0] PH_TRACK = 2'd2;

    typedef enum logic [2:0] {
        CFG_MAX_VOLTAGE     = 3'd0,
        CFG_COGNITIVE_GAIN  = 3'd1,
        CFG_SOCIAL_GAIN     = 3'd2,
        CFG_INERTIA_WEIGHT  = 3'd3,
        CFG_PARTICLE_COUNT  = 3'd4,
        CFG_ITERATION_LIMIT = 3'd5,
        CFG_POWER_THRESHOLD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [17:0] pos;
        logic signed [17:0] vel;
        logic signed [17:0] pbpos;
        logic [31:0]        pbpow;
    } t_row;

    function automatic logic signed [17:0] sat18(input logic signed [55:0] v);
        if (v > 56'sd131071) begin
            return 18'sd131071;
        end else if (v < -56'sd131072) begin
            return -18'sd131072;
        end else begin
            return v[17:0];
        end
    endfunction

endpackage

// ===== rtl/pso_mppt_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// pso_mppt_tracker_unit
// Particle swarm MPPT: one sample in, one reference voltage out.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    voltage, current, rand_a, rand_b
//   out      source     o_out_valid / i_out_stall  reference_voltage, phase
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One sample at a time; a re-seed in tracking may run the 37-step divider.
// Products share the single 33x19 multiplier; rows share the single-port
// particle RAM.
// Synchronous active-low reset; particle rows carry valid bits, no clear pass.
// The next sample is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module pso_mppt_tracker_unit #(
    parameter int MAX_PARTICLES = psomppt_pkg::DEF_MAX_PARTICLES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_voltage,
    input  logic [15:0]        i_current,
    input  logic [15:0]        i_rand_a,
    input  logic [15:0]        i_rand_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_reference_voltage,
    output logic [1:0]         o_phase
);

    localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_ACC  = 10'b0000000100,
        S_DEC  = 10'b0000001000,
        S_PRD  = 10'b0000010000,
        S_PUPD = 10'b0000100000,
        S_MRD  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_DFIN = 10'b0100000000,
        S_VEL  = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        M_PWR, M_PLACE, M_K2, M_G1, M_G2, M_T1, M_T2, M_TW
    } t_mstep;

    t_state r_state;
    logic   r_wr_pend, r_out_pend;

    logic [15:0] r_max_voltage, r_cog, r_soc, r_inertia;
    logic [4:0]  r_pcount;
    logic [7:0]  r_iter_lim;
    logic [31:0] r_thr;

    logic [15:0] r_volt, r_curr, r_ra, r_rb;
    logic [31:0] r_p, r_gb_pow, r_prev;
    logic signed [17:0] r_gb_pos;
    logic [CW-1:0] r_init_idx, r_pidx;
    logic [7:0]    r_iter;
    logic [IW-1:0] r_reseed, r_addr, r_main;

    psomppt_pkg::t_row r_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] r_vld;
    psomppt_pkg::t_row r_rdata, r_wrow;
    logic r_rvld;

    logic [1:0] r_ph;
    logic r_pre_set, r_sweep_end, r_trk_div, r_trk_pos;
    t_mstep r_mstep;
    logic signed [51:0] r_prod;
    logic [31:0] r_t1, r_t2;
    logic signed [53:0] r_acc;
    logic [36:0] r_quo;
    logic [15:0] r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic signed [17:0] r_ref;

    logic               r_out_valid;
    logic signed [17:0] r_out_ref;
    logic [1:0]         r_out_phase;

    logic [CW-1:0]      w_n;
    psomppt_pkg::t_row  w_row, w_prow, w_wdata;
    logic               w_we;
    logic signed [32:0] w_ma;
    logic signed [18:0] w_mb, w_d1, w_d2;
    logic signed [51:0] w_mp;
    logic signed [32:0] w_delta;
    logic signed [33:0] w_thr;
    logic               w_hit;
    logic [31:0]        w_dmag;
    logic [IW-1:0]      w_rs_i;
    logic               w_gupd;
    logic signed [17:0] w_gcand;
    logic [32:0]        w_k2sum;
    logic [16:0]        w_k2, w_step;
    logic signed [19:0] w_k2np;
    logic [53:0]        w_mag, w_rnd;
    logic signed [55:0] w_vs;
    logic signed [17:0] w_vel, w_npos;
    logic [16:0]        w_rsh;
    logic               w_ge;
    logic signed [38:0] w_q;
    logic signed [17:0] w_dpos;
    logic               w_out_free;

    assign o_in_stall          = (r_state != S_IDLE) || r_wr_pend || r_out_pend;
    assign o_out_valid         = r_out_valid;
    assign o_reference_voltage = r_out_ref;
    assign o_phase             = r_out_phase;
    assign w_out_free          = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_pcount < 5'd2) begin
            w_n = CW'(2);
        end else if (int'(r_pcount) > MAX_PARTICLES) begin
            w_n = CW'(MAX_PARTICLES);
        end else begin
            w_n = CW'(r_pcount);
        end
    end

    assign w_row = r_rvld ? r_rdata : '0;

    // best update for the particle measured last
    always_comb begin
        w_prow  = w_row;
        w_gupd  = 1'b0;
        w_gcand = w_row.pbpos;
        if (r_pre_set) begin
            w_prow.pbpow = r_p;
            w_gupd       = r_p > r_gb_pow;
        end else if (r_p > w_row.pbpow) begin
            w_prow.pbpos = w_row.pos;
            w_prow.pbpow = r_p;
            w_gcand      = w_row.pos;
            w_gupd       = r_p > r_gb_pow;
        end
    end

    assign w_we    = (r_state == S_PUPD) || r_wr_pend;
    assign w_wdata = (r_state == S_PUPD) ? w_prow : r_wrow;

    assign w_d1 = {w_row.pbpos[17], w_row.pbpos} - {w_row.pos[17], w_row.pos};
    assign w_d2 = {r_gb_pos[17], r_gb_pos} - {w_row.pos[17], w_row.pos};

    always_comb begin
        case (r_mstep)
            M_PWR:   begin w_ma = {17'b0, r_volt};        w_mb = {3'b0, r_curr}; end
            M_PLACE: begin w_ma = {17'b0, r_max_voltage}; w_mb = {3'b0, r_ra}; end
            M_K2:    begin w_ma = {17'b0, r_max_voltage}; w_mb = {3'b0, psomppt_pkg::K2_NUM}; end
            M_G1:    begin w_ma = {17'b0, r_cog};         w_mb = {3'b0, r_ra}; end
            M_G2:    begin w_ma = {17'b0, r_soc};         w_mb = {3'b0, r_rb}; end
            M_T1:    begin w_ma = {1'b0, r_t1};           w_mb = w_d1; end
            M_T2:    begin w_ma = {1'b0, r_t2};           w_mb = w_d2; end
            default: begin w_ma = {17'b0, r_inertia};     w_mb = {w_row.vel[17], w_row.vel}; end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    assign w_delta = $signed({1'b0, r_p}) - $signed({1'b0, r_prev});
    assign w_thr   = $signed({2'b0, r_thr});
    assign w_hit   = (34'(w_delta) > w_thr) || (34'(w_delta) < -w_thr);
    assign w_dmag  = w_delta[32] ? 32'(-w_delta) : w_delta[31:0];
    assign w_rs_i  = (CW'(r_reseed) >= w_n) ? '0 : r_reseed;

    assign w_k2sum = {1'b0, r_prod[31:0]} + 33'd32768;
    assign w_k2    = w_k2sum[32:16];
    assign w_step  = r_trk_pos ? w_k2 : (w_k2 >> 1);
    assign w_k2np  = (r_ra < psomppt_pkg::RND_066)
                   ? ($signed({{2{r_gb_pos[17]}}, r_gb_pos}) + $signed({3'b0, w_step}))
                   : ($signed({{2{r_gb_pos[17]}}, r_gb_pos}) - $signed({3'b0, w_step}));

    assign w_mag  = r_acc[53] ? 54'(-r_acc) : 54'(r_acc);
    assign w_rnd  = (w_mag + 54'd134217728) >> 28;
    assign w_vs   = r_acc[53] ? -$signed({2'b0, w_rnd}) : $signed({2'b0, w_rnd});
    assign w_vel  = psomppt_pkg::sat18(w_vs);
    assign w_npos = psomppt_pkg::sat18(56'(w_row.pos) + 56'(w_vel));

    assign w_rsh = {r_rem, r_quo[36]};
    assign w_ge  = w_rsh >= {1'b0, r_max_voltage};

    always_comb begin
        if (r_max_voltage == 16'd0) begin
            w_q = r_trk_pos ? 39'sd262144 : -39'sd262144;
        end else begin
            w_q = r_dneg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
        end
    end
    assign w_dpos = psomppt_pkg::sat18(56'(r_gb_pos) - 56'(w_q));

    // particle RAM, one address shared by read and write, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
        r_rvld  <= r_vld[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_voltage <= psomppt_pkg::RST_MAX_VOLTAGE;
            r_cog         <= psomppt_pkg::RST_COGNITIVE_GAIN;
            r_soc         <= psomppt_pkg::RST_SOCIAL_GAIN;
            r_inertia     <= psomppt_pkg::RST_INERTIA_WEIGHT;
            r_pcount      <= psomppt_pkg::RST_PARTICLE_COUNT;
            r_iter_lim    <= psomppt_pkg::RST_ITERATION_LIMIT;
            r_thr         <= psomppt_pkg::RST_POWER_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (psomppt_pkg::t_cfg_idx'(i_cfg_index))
                psomppt_pkg::CFG_MAX_VOLTAGE:     r_max_voltage <= i_cfg_data[15:0];
                psomppt_pkg::CFG_COGNITIVE_GAIN:  r_cog         <= i_cfg_data[15:0];
                psomppt_pkg::CFG_SOCIAL_GAIN:     r_soc         <= i_cfg_data[15:0];
                psomppt_pkg::CFG_INERTIA_WEIGHT:  r_inertia     <= i_cfg_data[15:0];
                psomppt_pkg::CFG_PARTICLE_COUNT:  r_pcount      <= i_cfg_data[4:0];
                psomppt_pkg::CFG_ITERATION_LIMIT: r_iter_lim    <= i_cfg_data[7:0];
                psomppt_pkg::CFG_POWER_THRESHOLD: r_thr         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pend   <= 1'b0;
            r_out_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_gb_pos    <= '0;
            r_gb_pow    <= '0;
            r_prev      <= '0;
            r_init_idx  <= '0;
            r_pidx      <= '0;
            r_iter      <= '0;
            r_reseed    <= '0;
        end else begin
            if (r_wr_pend) begin
                r_vld[r_addr] <= 1'b1;
                r_wr_pend     <= 1'b0;
                r_out_pend    <= 1'b1;
            end
            if (r_out_pend && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_ref   <= r_ref;
                r_out_phase <= r_ph;
                r_out_pend  <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_volt  <= i_voltage;
                        r_curr  <= i_current;
                        r_ra    <= i_rand_a;
                        r_rb    <= i_rand_b;
                        r_mstep <= M_PWR;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mp;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_mstep)
                        M_PWR: begin
                            r_p     <= r_prod[31:0];
                            r_state <= S_DEC;
                        end
                        M_PLACE: begin
                            r_wrow.pos   <= {2'b0, r_prod[31:16]};
                            r_wrow.pbpos <= {2'b0, r_prod[31:16]};
                            r_wrow.pbpow <= '0;
                            r_wrow.vel   <= w_row.vel;
                            r_ref        <= {2'b0, r_prod[31:16]};
                            r_wr_pend    <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                        M_K2: begin
                            r_wrow    <= '{pos: psomppt_pkg::sat18(56'(w_k2np)),
                                           vel: w_row.vel, pbpos: w_row.pbpos,
                                           pbpow: w_row.pbpow};
                            r_ref     <= psomppt_pkg::sat18(56'(w_k2np));
                            r_wr_pend <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                        M_G1: begin
                            r_t1    <= r_prod[31:0];
                            r_mstep <= M_G2;
                            r_state <= S_MUL;
                        end
                        M_G2: begin
                            r_t2    <= r_prod[31:0];
                            r_mstep <= M_T1;
                            r_state <= S_MUL;
                        end
                        M_T1: begin
                            r_acc   <= 54'(r_prod);
                            r_mstep <= M_T2;
                            r_state <= S_MUL;
                        end
                        M_T2: begin
                            r_acc   <= r_acc + 54'(r_prod);
                            r_mstep <= M_TW;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_acc   <= r_acc + (54'(r_prod) <<< 16);
                            r_state <= S_VEL;
                        end
                    endcase
                end
                S_DEC: begin
                    if (r_init_idx < w_n) begin
                        r_ph        <= psomppt_pkg::PH_INIT;
                        r_sweep_end <= 1'b0;
                        r_pre_set   <= 1'b1;
                        r_main      <= IW'(r_init_idx);
                        r_init_idx  <= r_init_idx + 1'b1;
                        if (r_init_idx != '0) begin
                            r_addr  <= IW'(r_init_idx - 1'b1);
                            r_state <= S_PRD;
                        end else begin
                            r_addr  <= IW'(r_init_idx);
                            r_state <= S_MRD;
                        end
                    end else if (r_iter < r_iter_lim) begin
                        r_ph <= psomppt_pkg::PH_SWARM;
                        if (r_pidx < w_n) begin
                            r_sweep_end <= 1'b0;
                            r_main      <= IW'(r_pidx);
                            r_pidx      <= r_pidx + 1'b1;
                            if (r_iter == 8'd0 && r_pidx == '0) begin
                                r_pre_set <= 1'b1;
                                r_addr    <= IW'(w_n - 1'b1);
                                r_state   <= S_PRD;
                            end else if (r_pidx != '0) begin
                                r_pre_set <= 1'b0;
                                r_addr    <= IW'(r_pidx - 1'b1);
                                r_state   <= S_PRD;
                            end else begin
                                r_addr  <= IW'(r_pidx);
                                r_state <= S_MRD;
                            end
                        end else begin
                            r_pre_set   <= 1'b0;
                            r_sweep_end <= 1'b1;
                            r_addr      <= IW'(w_n - 1'b1);
                            r_iter      <= r_iter + 8'd1;
                            r_pidx      <= '0;
                            r_state     <= S_PRD;
                        end
                    end else begin
                        r_ph        <= psomppt_pkg::PH_TRACK;
                        r_sweep_end <= 1'b0;
                        r_prev      <= r_p;
                        if (w_hit) begin
                            r_addr    <= w_rs_i;
                            r_reseed  <= (CW'(w_rs_i) + 1'b1 >= w_n) ? '0 : w_rs_i + 1'b1;
                            r_trk_div <= r_ra < psomppt_pkg::RND_033;
                            r_trk_pos <= !w_delta[32];
                            r_dneg    <= w_delta[32];
                            r_quo     <= {1'b0, w_dmag, 4'b0} + {3'b0, w_dmag, 2'b0};
                            r_rem     <= '0;
                            r_dcnt    <= 6'd37;
                            r_state   <= S_MRD;
                        end else begin
                            r_ref      <= r_gb_pos;
                            r_out_pend <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_PRD: begin
                    r_state <= S_PUPD;
                end
                S_PUPD: begin
                    r_vld[r_addr] <= 1'b1;
                    if (w_gupd) begin
                        r_gb_pos <= w_gcand;
                        r_gb_pow <= r_p;
                    end
                    if (r_sweep_end) begin
                        r_prev     <= w_gupd ? r_p : r_gb_pow;
                        r_ref      <= w_gupd ? w_gcand : r_gb_pos;
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_addr  <= r_main;
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    if (r_ph == psomppt_pkg::PH_INIT) begin
                        r_mstep <= M_PLACE;
                        r_state <= S_MUL;
                    end else if (r_ph == psomppt_pkg::PH_SWARM) begin
                        r_mstep <= M_G1;
                        r_state <= S_MUL;
                    end else if (r_trk_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_mstep <= M_K2;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? 16'(w_rsh - {1'b0, r_max_voltage}) : w_rsh[15:0];
                    r_quo  <= {r_quo[35:0], w_ge};
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd1) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_wrow    <= '{pos: w_dpos, vel: w_row.vel, pbpos: w_row.pbpos,
                                   pbpow: w_row.pbpow};
                    r_ref     <= w_dpos;
                    r_wr_pend <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_VEL: begin
                    r_wrow    <= '{pos: w_npos, vel: w_vel, pbpos: w_row.pbpos,
                                   pbpow: w_row.pbpow};
                    r_ref     <= w_npos;
                    r_wr_pend <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/psomppt_checker.sv =====
// ----------------------------------------------------------------------------
// psomppt_checker
// Port-level checks for pso_mppt_tracker_unit, attached by bind.
// ----------------------------------------------------------------------------
module psomppt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [17:0] o_reference_voltage,
    input logic [1:0]         o_phase
);

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer not followed by busy");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("state after reset not idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_reference_voltage) && $stable(o_phase)))
        else $error("stalled result changed");

endmodule

bind pso_mppt_tracker_unit psomppt_checker u_psomppt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_reference_voltage (o_reference_voltage),
    .o_phase             (o_phase)
);
